[rtl/xrg_pkg.sv]
package xrg_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned WIDE_W = 62;
	localparam int unsigned FRAC_W = 23;
	localparam int unsigned DIV_CNT_W = 6;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(WIDE_W - 1);

	localparam logic [63:0] GAMMA_ADD = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [63:0] MIX_MUL_A = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [63:0] MIX_MUL_B = 64'h94d0_49bb_1331_11eb;

	typedef enum logic [1:0] {
		CMD_RESEED = 2'd0,
		CMD_UNIT   = 2'd1,
		CMD_WIDE   = 2'd2,
		CMD_RANGE  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] low_bound;
		logic signed [31:0] high_bound;
	} cmd_item_t;

	typedef struct packed {
		logic [61:0]        draw_value;
		logic signed [31:0] ranged_value;
		logic               range_error;
	} res_item_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_CAPTURE,
		DP_SEED,
		DP_GAMMA,
		DP_MUL0,
		DP_MUL1,
		DP_MUL2,
		DP_X27,
		DP_FIN,
		DP_DRAW1,
		DP_DRAW2,
		DP_DIV,
		DP_OUT
	} dp_op_t;

	typedef enum logic [3:0] {
		ST_SEED,
		ST_GAMMA,
		ST_MA0,
		ST_MA1,
		ST_MA2,
		ST_X27,
		ST_MB0,
		ST_MB1,
		ST_MB2,
		ST_FIN,
		ST_IDLE,
		ST_DRAW1,
		ST_DRAW2,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		dp_op_t op;
		logic   mul_b;
		logic   seed_zero;
		logic   fin_last;
	} dp_ctrl_t;

	typedef struct packed {
		cmd_t cmd;
		logic range_err;
	} dp_status_t;

endpackage

[rtl/xoshiro128ss_random_generator_core.sv]
// xoshiro128** generator with splitmix64 seeding.
// Command channel: cmd_valid/cmd_stall carry one cmd_item (command, low_bound,
// high_bound). An item is taken when cmd_valid is high and cmd_stall is low.
// Result channel: res_valid/res_stall carry one res_item for every command.
// seed_we/seed_wdata write the seed register; the user must do so only while
// the block is idle (the block does not enforce this). Unit draws once, wide
// twice; range draws twice, then a 62-step restoring divider forms the
// remainder (skipped for an empty range). Reseed runs two splitmix64 rounds,
// each multiply done as three 32x32 partial products on one multiplier.
// One item is in work at a time; the next item can be taken in the cycle after
// the previous result is loaded, even while that result still waits.
// After reset the block loads the state from seed zero, and holds cmd_stall
// high during that time. The seed register resets to 0.
// While the receiver stalls, the result is held; a finished item then waits
// in the controller until the output register is free.
module xoshiro128ss_random_generator_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  xrg_pkg::cmd_item_t cmd_item,
	output logic               res_valid,
	input  logic               res_stall,
	output xrg_pkg::res_item_t res_item,
	input  logic               seed_we,
	input  logic [31:0]        seed_wdata
);

	xrg_pkg::dp_ctrl_t   ctrl;
	xrg_pkg::dp_status_t status;

	xrg_controller u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_command (cmd_item.command),
		.cmd_stall   (cmd_stall),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.status      (status),
		.ctrl        (ctrl)
	);

	xrg_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_item   (cmd_item),
		.seed_we    (seed_we),
		.seed_wdata (seed_wdata),
		.ctrl       (ctrl),
		.status     (status),
		.res_item   (res_item)
	);

endmodule

[rtl/xrg_datapath.sv]
module xrg_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  xrg_pkg::cmd_item_t  cmd_item,
	input  logic                seed_we,
	input  logic [31:0]         seed_wdata,
	input  xrg_pkg::dp_ctrl_t   ctrl,
	output xrg_pkg::dp_status_t status,
	output xrg_pkg::res_item_t  res_item
);

	logic [31:0]        seed_q;
	logic [31:0]        w0_q, w1_q, w2_q, w3_q;
	logic [63:0]        acc_q, z_q, prod_q, r0_q;
	logic [31:0]        draw1_q;
	logic [61:0]        wide_q;
	logic [31:0]        rem_q, span_q;
	logic signed [31:0] lo_q;
	xrg_pkg::cmd_t      cmd_q;
	logic               err_q;
	xrg_pkg::res_item_t out_q;
	xrg_pkg::res_item_t out_d;

	logic [63:0] mul_k, gamma_sum, fin_mix, prod;
	logic [31:0] mul_a, mul_bop;
	logic [31:0] t5, rot7, draw_out;
	logic [31:0] n0, n1, n2, n3;
	logic [32:0] rem_sh;
	logic [31:0] wn0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (seed_we) begin
			seed_q <= seed_wdata;
		end
	end

	always_comb begin
		mul_k = ctrl.mul_b ? xrg_pkg::MIX_MUL_B : xrg_pkg::MIX_MUL_A;
		mul_a = (ctrl.op == xrg_pkg::DP_MUL1) ? z_q[63:32] : z_q[31:0];
		mul_bop = (ctrl.op == xrg_pkg::DP_MUL2) ? mul_k[63:32] : mul_k[31:0];
		prod = 64'(mul_a) * 64'(mul_bop);
		gamma_sum = acc_q + xrg_pkg::GAMMA_ADD;
		fin_mix = prod_q ^ (prod_q >> 31);
		wn0 = r0_q[31:0];
		if ((r0_q | fin_mix) == 64'd0) begin
			wn0 = 32'd1;
		end
		t5 = w0_q + (w0_q << 2);
		rot7 = {t5[24:0], t5[31:25]};
		draw_out = rot7 + (rot7 << 3);
		n2 = w2_q ^ w0_q;
		n3 = w3_q ^ w1_q;
		n1 = w1_q ^ n2;
		n0 = w0_q ^ n3;
		rem_sh = {rem_q, wide_q[61]};
		out_d = '0;
		case (cmd_q)
			xrg_pkg::CMD_UNIT: begin
				out_d.draw_value = 62'(draw1_q[31:9]);
			end
			xrg_pkg::CMD_WIDE: begin
				out_d.draw_value = wide_q;
			end
			xrg_pkg::CMD_RANGE: begin
				out_d.range_error = err_q;
				out_d.ranged_value = err_q ? lo_q : signed'(32'(lo_q + rem_q));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			xrg_pkg::DP_CAPTURE: begin
				cmd_q <= xrg_pkg::cmd_t'(cmd_item.command);
				lo_q <= cmd_item.low_bound;
				span_q <= 32'(cmd_item.high_bound - cmd_item.low_bound);
				err_q <= (cmd_item.high_bound <= cmd_item.low_bound);
			end
			xrg_pkg::DP_SEED: begin
				acc_q <= ctrl.seed_zero ? 64'd0 : {32'd0, seed_q};
			end
			xrg_pkg::DP_GAMMA: begin
				acc_q <= gamma_sum;
				z_q <= gamma_sum ^ (gamma_sum >> 30);
			end
			xrg_pkg::DP_MUL0: begin
				prod_q <= prod;
			end
			xrg_pkg::DP_MUL1, xrg_pkg::DP_MUL2: begin
				prod_q[63:32] <= prod_q[63:32] + prod[31:0];
			end
			xrg_pkg::DP_X27: begin
				z_q <= prod_q ^ (prod_q >> 27);
			end
			xrg_pkg::DP_FIN: begin
				if (!ctrl.fin_last) begin
					r0_q <= fin_mix;
				end else begin
					w0_q <= wn0;
					w1_q <= r0_q[63:32];
					w2_q <= fin_mix[31:0];
					w3_q <= fin_mix[63:32];
				end
			end
			xrg_pkg::DP_DRAW1, xrg_pkg::DP_DRAW2: begin
				w0_q <= n0;
				w1_q <= n1;
				w2_q <= n2 ^ (w1_q << 9);
				w3_q <= {n3[20:0], n3[31:21]};
				if (ctrl.op == xrg_pkg::DP_DRAW1) begin
					draw1_q <= draw_out;
				end else begin
					wide_q <= {draw1_q[31:1], draw_out[31:1]};
					rem_q <= '0;
				end
			end
			xrg_pkg::DP_DIV: begin
				wide_q <= {wide_q[60:0], 1'b0};
				if (rem_sh >= {1'b0, span_q}) begin
					rem_q <= 32'(rem_sh - {1'b0, span_q});
				end else begin
					rem_q <= rem_sh[31:0];
				end
			end
			xrg_pkg::DP_OUT: begin
				out_q <= out_d;
			end
			default: begin
			end
		endcase
	end

	assign status.cmd = cmd_q;
	assign status.range_err = err_q;
	assign res_item = out_q;

endmodule

[rtl/xrg_controller.sv]
module xrg_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  logic [1:0]          cmd_command,
	output logic                cmd_stall,
	output logic                res_valid,
	input  logic                res_stall,
	input  xrg_pkg::dp_status_t status,
	output xrg_pkg::dp_ctrl_t   ctrl
);

	xrg_pkg::state_t state_q, state_d;
	logic                          round_q, round_d;
	logic                          init_q, init_d;
	logic                          res_valid_q, res_valid_d;
	logic [xrg_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xrg_pkg::ST_SEED;
			round_q <= 1'b0;
			init_q <= 1'b1;
			res_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			round_q <= round_d;
			init_q <= init_d;
			res_valid_q <= res_valid_d;
			cnt_q <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		round_d = round_q;
		init_d = init_q;
		cnt_d = cnt_q;
		res_valid_d = res_valid_q && res_stall;
		ctrl.op = xrg_pkg::DP_NONE;
		ctrl.mul_b = 1'b0;
		ctrl.seed_zero = init_q;
		ctrl.fin_last = round_q;
		cmd_stall = 1'b1;
		unique case (state_q)
			xrg_pkg::ST_SEED: begin
				ctrl.op = xrg_pkg::DP_SEED;
				round_d = 1'b0;
				state_d = xrg_pkg::ST_GAMMA;
			end
			xrg_pkg::ST_GAMMA: begin
				ctrl.op = xrg_pkg::DP_GAMMA;
				state_d = xrg_pkg::ST_MA0;
			end
			xrg_pkg::ST_MA0: begin
				ctrl.op = xrg_pkg::DP_MUL0;
				state_d = xrg_pkg::ST_MA1;
			end
			xrg_pkg::ST_MA1: begin
				ctrl.op = xrg_pkg::DP_MUL1;
				state_d = xrg_pkg::ST_MA2;
			end
			xrg_pkg::ST_MA2: begin
				ctrl.op = xrg_pkg::DP_MUL2;
				state_d = xrg_pkg::ST_X27;
			end
			xrg_pkg::ST_X27: begin
				ctrl.op = xrg_pkg::DP_X27;
				state_d = xrg_pkg::ST_MB0;
			end
			xrg_pkg::ST_MB0: begin
				ctrl.op = xrg_pkg::DP_MUL0;
				ctrl.mul_b = 1'b1;
				state_d = xrg_pkg::ST_MB1;
			end
			xrg_pkg::ST_MB1: begin
				ctrl.op = xrg_pkg::DP_MUL1;
				ctrl.mul_b = 1'b1;
				state_d = xrg_pkg::ST_MB2;
			end
			xrg_pkg::ST_MB2: begin
				ctrl.op = xrg_pkg::DP_MUL2;
				ctrl.mul_b = 1'b1;
				state_d = xrg_pkg::ST_FIN;
			end
			xrg_pkg::ST_FIN: begin
				ctrl.op = xrg_pkg::DP_FIN;
				if (!round_q) begin
					round_d = 1'b1;
					state_d = xrg_pkg::ST_GAMMA;
				end else if (init_q) begin
					init_d = 1'b0;
					state_d = xrg_pkg::ST_IDLE;
				end else begin
					state_d = xrg_pkg::ST_OUT;
				end
			end
			xrg_pkg::ST_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					ctrl.op = xrg_pkg::DP_CAPTURE;
					if (xrg_pkg::cmd_t'(cmd_command) == xrg_pkg::CMD_RESEED) begin
						state_d = xrg_pkg::ST_SEED;
					end else begin
						state_d = xrg_pkg::ST_DRAW1;
					end
				end
			end
			xrg_pkg::ST_DRAW1: begin
				ctrl.op = xrg_pkg::DP_DRAW1;
				if (status.cmd == xrg_pkg::CMD_UNIT) begin
					state_d = xrg_pkg::ST_OUT;
				end else begin
					state_d = xrg_pkg::ST_DRAW2;
				end
			end
			xrg_pkg::ST_DRAW2: begin
				ctrl.op = xrg_pkg::DP_DRAW2;
				cnt_d = '0;
				if (status.cmd == xrg_pkg::CMD_RANGE && !status.range_err) begin
					state_d = xrg_pkg::ST_DIV;
				end else begin
					state_d = xrg_pkg::ST_OUT;
				end
			end
			xrg_pkg::ST_DIV: begin
				ctrl.op = xrg_pkg::DP_DIV;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == xrg_pkg::DIV_LAST) begin
					state_d = xrg_pkg::ST_OUT;
				end
			end
			xrg_pkg::ST_OUT: begin
				if (!res_valid_q || !res_stall) begin
					ctrl.op = xrg_pkg::DP_OUT;
					res_valid_d = 1'b1;
					state_d = xrg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = xrg_pkg::ST_IDLE;
			end
		endcase
	end

	assign res_valid = res_valid_q;

endmodule

[verif/xoshiro128ss_random_generator_core_tb.sv]
`timescale 1ns / 1ps

module xoshiro128ss_random_generator_core_tb;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned REPORT_LIMIT = 10;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cmd_valid = 1'b0;
	logic               cmd_stall;
	xrg_pkg::cmd_item_t cmd_item = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	xrg_pkg::res_item_t res_item;
	logic               seed_we = 1'b0;
	logic [31:0]        seed_wdata = '0;

	logic [31:0] gen_words [4];
	logic [31:0] seed_model;

	xrg_pkg::cmd_item_t pending_cmds [$];
	xrg_pkg::res_item_t expected_results [$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned mismatch_total = 0;
	int unsigned stray_results = 0;
	int unsigned checked_results = 0;
	int unsigned cycle_count = 0;

	xoshiro128ss_random_generator_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_item(cmd_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item(res_item),
		.seed_we(seed_we),
		.seed_wdata(seed_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] splitmix_out(input logic [63:0] acc);
		logic [63:0] z;
		z = acc;
		z = (z ^ (z >> 30)) * xrg_pkg::MIX_MUL_A;
		z = (z ^ (z >> 27)) * xrg_pkg::MIX_MUL_B;
		return z ^ (z >> 31);
	endfunction

	function automatic void reload_words(input logic [31:0] seed);
		logic [63:0] acc;
		logic [63:0] r0;
		logic [63:0] r1;
		acc = {32'd0, seed} + xrg_pkg::GAMMA_ADD;
		r0 = splitmix_out(acc);
		acc = acc + xrg_pkg::GAMMA_ADD;
		r1 = splitmix_out(acc);
		gen_words[0] = r0[31:0];
		gen_words[1] = r0[63:32];
		gen_words[2] = r1[31:0];
		gen_words[3] = r1[63:32];
		if ((gen_words[0] | gen_words[1] | gen_words[2] | gen_words[3]) == 32'd0) begin
			gen_words[0] = 32'd1;
		end
	endfunction

	function automatic logic [31:0] next_word();
		logic [31:0] scaled;
		logic [31:0] out_word;
		logic [31:0] shifted;
		logic [31:0] w3;
		scaled = gen_words[0] * 32'd5;
		out_word = {scaled[24:0], scaled[31:25]} * 32'd9;
		shifted = gen_words[1] << 9;
		gen_words[2] = gen_words[2] ^ gen_words[0];
		gen_words[3] = gen_words[3] ^ gen_words[1];
		gen_words[1] = gen_words[1] ^ gen_words[2];
		gen_words[0] = gen_words[0] ^ gen_words[3];
		gen_words[2] = gen_words[2] ^ shifted;
		w3 = gen_words[3];
		gen_words[3] = {w3[20:0], w3[31:21]};
		return out_word;
	endfunction

	function automatic logic [61:0] next_wide();
		logic [31:0] first_word;
		logic [31:0] second_word;
		first_word = next_word();
		second_word = next_word();
		return {first_word[31:1], second_word[31:1]};
	endfunction

	function automatic xrg_pkg::res_item_t predict_result(input xrg_pkg::cmd_item_t it);
		xrg_pkg::res_item_t r;
		logic [31:0]        w;
		logic [61:0]        wide;
		logic signed [63:0] lo64;
		logic signed [63:0] hi64;
		logic [63:0]        span;
		logic [63:0]        sum;
		r = '0;
		case (xrg_pkg::cmd_t'(it.command))
			xrg_pkg::CMD_RESEED: begin
				reload_words(seed_model);
			end
			xrg_pkg::CMD_UNIT: begin
				w = next_word();
				r.draw_value = 62'(w >> 9);
			end
			xrg_pkg::CMD_WIDE: begin
				r.draw_value = next_wide();
			end
			default: begin
				wide = next_wide();
				lo64 = 64'($signed(it.low_bound));
				hi64 = 64'($signed(it.high_bound));
				if (hi64 <= lo64) begin
					r.ranged_value = it.low_bound;
					r.range_error = 1'b1;
				end else begin
					span = hi64 - lo64;
					sum = lo64 + ({2'b00, wide} % span);
					r.ranged_value = sum[31:0];
				end
			end
		endcase
		return r;
	endfunction

	function automatic void queue_cmd(input xrg_pkg::cmd_t cmd, input logic [31:0] lo,
		input logic [31:0] hi);
		xrg_pkg::cmd_item_t it;
		it.command = cmd;
		it.low_bound = lo;
		it.high_bound = hi;
		pending_cmds.push_back(it);
	endfunction

	function automatic void queue_random_cmd();
		logic [31:0] lo;
		logic [31:0] hi;
		lo = $urandom();
		hi = $urandom();
		case ($urandom_range(5))
			0: hi = lo + $urandom_range(1, 16);
			1: hi = lo + $urandom_range(1, 1000000);
			2: hi = lo;
			3: lo = 32'h8000_0000;
			4: hi = 32'h7fff_ffff;
			default: ;
		endcase
		queue_cmd(xrg_pkg::cmd_t'($urandom_range(3)), lo, hi);
	endfunction

	task automatic write_seed(input logic [31:0] value);
		@(posedge clk);
		seed_we <= 1'b1;
		seed_wdata <= value;
		@(posedge clk);
		seed_we <= 1'b0;
		seed_wdata <= $urandom();
		seed_model = value;
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (pending_cmds.size() != 0 || cmd_valid || expected_results.size() != 0);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd_item <= '0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				expected_results.push_back(predict_result(cmd_item));
			end
			if (!cmd_valid || !cmd_stall) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cmd_valid <= 1'b1;
					cmd_item <= pending_cmds.pop_front();
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		xrg_pkg::res_item_t exp_item;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					stray_results++;
					$display("Unexpected result: draw %h ranged %h error %b",
						res_item.draw_value, res_item.ranged_value, res_item.range_error);
				end else begin
					exp_item = expected_results.pop_front();
					if (res_item.draw_value !== exp_item.draw_value ||
						res_item.ranged_value !== exp_item.ranged_value ||
						res_item.range_error !== exp_item.range_error) begin
						mismatch_total++;
						if (mismatch_total <= REPORT_LIMIT) begin
							$display("Mismatch on result %0d: draw %h/%h ranged %h/%h error %b/%b",
								checked_results, exp_item.draw_value, res_item.draw_value,
								exp_item.ranged_value, res_item.ranged_value,
								exp_item.range_error, res_item.range_error);
						end
					end
					checked_results++;
				end
			end
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("xoshiro128ss_random_generator_core_tb: FAIL");
			$finish;
		end
	end

	initial begin
		seed_model = '0;
		reload_words(seed_model);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk);
		while (cmd_stall);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0, 1: begin
					send_idle_pct = 20;
					recv_idle_pct = 75;
				end
				2: begin
					send_idle_pct = 75;
					recv_idle_pct = 20;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (phase)
				0: write_seed(32'hffff_ffff);
				1: write_seed(32'h0000_0000);
				default: write_seed($urandom());
			endcase
			if (phase == 0) begin
				queue_cmd(xrg_pkg::CMD_UNIT, 32'h0, 32'h0);
				queue_cmd(xrg_pkg::CMD_WIDE, 32'hffff_ffff, 32'hffff_ffff);
				queue_cmd(xrg_pkg::CMD_RANGE, 32'h8000_0000, 32'h7fff_ffff);
				queue_cmd(xrg_pkg::CMD_RANGE, 32'h0, 32'h1);
				queue_cmd(xrg_pkg::CMD_RANGE, 32'hffff_fffb, 32'h5);
				queue_cmd(xrg_pkg::CMD_RESEED, 32'h1234_5678, 32'h9abc_def0);
				queue_cmd(xrg_pkg::CMD_UNIT, 32'h0, 32'h0);
				queue_cmd(xrg_pkg::CMD_WIDE, 32'h0, 32'h0);
				queue_cmd(xrg_pkg::CMD_RANGE, 32'h7fff_ffff, 32'h8000_0000);
				queue_cmd(xrg_pkg::CMD_RANGE, 32'h0000_0064, 32'h0000_0064);
				queue_cmd(xrg_pkg::CMD_RANGE, 32'h8000_0000, 32'h8000_0001);
				queue_cmd(xrg_pkg::CMD_RANGE, 32'h7fff_fffe, 32'h7fff_ffff);
				queue_cmd(xrg_pkg::CMD_RANGE, 32'h8000_0000, 32'h8000_0000);
				queue_cmd(xrg_pkg::CMD_RANGE, 32'h0000_0010, 32'hffff_fff0);
				queue_cmd(xrg_pkg::CMD_RESEED, 32'h0, 32'h0);
				queue_cmd(xrg_pkg::CMD_RANGE, 32'h0000_0000, 32'h7fff_ffff);
				queue_cmd(xrg_pkg::CMD_RANGE, 32'h8000_0000, 32'h0000_0000);
				queue_cmd(xrg_pkg::CMD_UNIT, 32'hffff_ffff, 32'h0);
				queue_cmd(xrg_pkg::CMD_WIDE, 32'h5555_5555, 32'haaaa_aaaa);
				queue_cmd(xrg_pkg::CMD_RANGE, 32'haaaa_aaaa, 32'h5555_5555);
				wait_drained();
			end else begin
				for (int half = 0; half < 2; half++) begin
					for (int n = 0; n < 114; n++) begin
						queue_random_cmd();
					end
					// The sender holds off here until every outstanding item has returned.
					wait_drained();
				end
			end
			repeat (4) @(posedge clk);
		end

		repeat (80) @(posedge clk);
		if (mismatch_total == 0 && stray_results == 0 && expected_results.size() == 0) begin
			$display("xoshiro128ss_random_generator_core_tb: PASS");
		end else begin
			$display("xoshiro128ss_random_generator_core_tb: FAIL");
		end
		$finish;
	end

endmodule
